[hw/rtl/tcw_pkg.sv]
// shared types and constants for the text console writer
// no dependencies; used by scoped names from text_console_writer
`timescale 1ns / 1ps

package tcw_pkg;

    // fixed field widths of the command and result beats
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int POS_X_W    = 7;
    localparam int POS_Y_W    = 5;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CELL_W     = 16;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] ATTR_NORMAL  = 8'h07;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 2'd0,
        CMD_PUT_AT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_PUT,
        S_PUT_AT,
        S_READ,
        S_RDWAIT,
        S_AREA,
        S_LIMIT,
        S_PREFETCH,
        S_SWEEP,
        S_RESULT
    } t_state;

endpackage

[hw/rtl/tcw_ram.sv]
// generic simple dual-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tcw_mac.sv]
// shared multiply-add unit, registered result: p = a * b + c
// no dependencies
`timescale 1ns / 1ps

module tcw_mac #(
    parameter int A_W = 5,
    parameter int B_W = 7,
    parameter int P_W = 11
) (
    input  logic           i_clk,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    input  logic [B_W-1:0] i_c,
    output logic [P_W-1:0] o_p
);

    logic [P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= P_W'(P_W'(i_a) * P_W'(i_b) + P_W'(i_c));
    end

    assign o_p = r_p;

endmodule

[hw/rtl/text_console_writer.sv]
// text console writer: put at cursor, put-at, read, clear and a put that scrolls
// each run from accept through to the result strobe, after which the block can
// accept the next command; one command at a time
// the cell store's single write port and the shared multiply-add set the pace
// after reset the store is zeroed, one cell a cycle, with busy high; results
// cannot be stalled by the receiver
// depends on tcw_pkg, tcw_ram, tcw_mac
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcw_pkg::CFG_W-1:0]      i_cfg_data,
    // command side
    input  logic                           start,
    output logic                           busy,
    input  logic [tcw_pkg::CMD_W-1:0]      i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::POS_X_W-1:0]    i_pos_x,
    input  logic [tcw_pkg::POS_Y_W-1:0]    i_pos_y,
    // result side
    output logic                           o_done,
    output logic                           o_echo_valid,
    output logic [tcw_pkg::CHAR_W-1:0]     o_echo_byte,
    output logic [tcw_pkg::POS_X_W-1:0]    o_cursor_col,
    output logic [tcw_pkg::POS_Y_W-1:0]    o_cursor_row,
    output logic                           o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]     o_read_char,
    output logic [tcw_pkg::CHAR_W-1:0]     o_read_attr
);

    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int W_RST  = (80 > MAX_COLS) ? MAX_COLS : 80;
    localparam int H_RST  = (25 > MAX_ROWS) ? MAX_ROWS : 25;

    // sequencer state
    tcw_pkg::t_state r_state, n_state;

    // configuration
    logic [COL_W-1:0] r_w;
    logic [ROW_W-1:0] r_h;

    // cursor
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_line;

    // latched command beat
    tcw_pkg::t_cmd                r_cmd;
    logic [tcw_pkg::CHAR_W-1:0]   r_ch;
    logic [COL_W-1:0]             r_px;
    logic [ROW_W-1:0]             r_py;

    // sweep control (reset clear, clear screen, scroll)
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_last;
    logic [ADDR_W-1:0] r_lim;
    logic              r_move;
    logic              r_init;

    // result registers
    logic                       r_echo_valid;
    logic [tcw_pkg::CHAR_W-1:0] r_echo_byte;
    logic                       r_scrolled;
    logic [tcw_pkg::CHAR_W-1:0] r_rd_char;
    logic [tcw_pkg::CHAR_W-1:0] r_rd_attr;

    // ram and multiply-add hookup
    logic                       ram_we, ram_re;
    logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
    logic [ROW_W-1:0]           mac_a;
    logic [COL_W-1:0]           mac_b, mac_c;
    logic [ADDR_W-1:0]          mac_p;

    logic                       accept;
    logic                       is_nl;
    logic                       sweep_end;
    logic [ADDR_W:0]            sweep_rd;
    logic [COL_W-1:0]           put_col;
    logic [ROW_W-1:0]           put_line;
    logic                       put_wrap;
    logic                       put_scroll;
    logic [COL_W-1:0]           px_clamped;
    logic [ROW_W-1:0]           py_clamped;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcw_mac #(
        .A_W (ROW_W),
        .B_W (COL_W),
        .P_W (ADDR_W)
    ) u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_p   (mac_p)
    );

    assign accept = (r_state == tcw_pkg::S_IDLE) && start;
    assign is_nl  = (r_ch == tcw_pkg::NEWLINE_CODE);

    // positions for put-at and read are clamped to the full store geometry
    assign px_clamped = (int'(i_pos_x) > MAX_COLS - 1) ? COL_W'(MAX_COLS - 1)
                                                       : COL_W'(i_pos_x);
    assign py_clamped = (int'(i_pos_y) > MAX_ROWS - 1) ? ROW_W'(MAX_ROWS - 1)
                                                       : ROW_W'(i_pos_y);

    // cursor advance for put at cursor: a newline never wraps, it starts the next line
    always_comb begin
        put_col  = is_nl ? '0 : COL_W'(r_col + 1'b1);
        put_wrap = !is_nl && (put_col >= r_w);
        if (put_wrap) begin
            put_col = '0;
        end
        put_line   = ROW_W'(r_line + ((is_nl || put_wrap) ? 1'b1 : 1'b0));
        put_scroll = (put_line >= r_h);
        if (put_scroll) begin
            put_line = ROW_W'(r_h - 1'b1);
        end
    end

    // sweep reads one cell ahead of the write, shifted by one row of w cells
    assign sweep_rd  = (ADDR_W+1)'(r_idx) + (ADDR_W+1)'(r_w) + (ADDR_W+1)'(1);
    assign sweep_end = (r_idx == r_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (start) begin
                    if (tcw_pkg::t_cmd'(i_cmd) == tcw_pkg::CMD_CLEAR) begin
                        n_state = tcw_pkg::S_AREA;
                    end else begin
                        n_state = tcw_pkg::S_ADDR;
                    end
                end
            end
            tcw_pkg::S_ADDR: begin
                case (r_cmd)
                    tcw_pkg::CMD_PUT:    n_state = tcw_pkg::S_PUT;
                    tcw_pkg::CMD_PUT_AT: n_state = tcw_pkg::S_PUT_AT;
                    default:             n_state = tcw_pkg::S_READ;
                endcase
            end
            tcw_pkg::S_PUT: begin
                n_state = put_scroll ? tcw_pkg::S_AREA : tcw_pkg::S_RESULT;
            end
            tcw_pkg::S_PUT_AT:   n_state = tcw_pkg::S_RESULT;
            tcw_pkg::S_READ:     n_state = tcw_pkg::S_RDWAIT;
            tcw_pkg::S_RDWAIT:   n_state = tcw_pkg::S_RESULT;
            tcw_pkg::S_AREA:     n_state = tcw_pkg::S_LIMIT;
            tcw_pkg::S_LIMIT:    n_state = tcw_pkg::S_PREFETCH;
            tcw_pkg::S_PREFETCH: n_state = tcw_pkg::S_SWEEP;
            tcw_pkg::S_SWEEP: begin
                if (sweep_end) begin
                    n_state = r_init ? tcw_pkg::S_IDLE : tcw_pkg::S_RESULT;
                end
            end
            tcw_pkg::S_RESULT:   n_state = tcw_pkg::S_IDLE;
            default:             n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: store port, multiply-add operands, handshake
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = mac_p;
        // default operands: cursor address line * w + col
        mac_a     = r_line;
        mac_b     = r_w;
        mac_c     = r_col;
        busy      = (r_state != tcw_pkg::S_IDLE);
        o_done    = 1'b0;
        case (r_state)
            tcw_pkg::S_ADDR: begin
                if (r_cmd != tcw_pkg::CMD_PUT) begin
                    // put-at and read use the fixed stride
                    mac_a = r_py;
                    mac_b = COL_W'(MAX_COLS);
                    mac_c = r_px;
                end
            end
            tcw_pkg::S_PUT, tcw_pkg::S_PUT_AT: begin
                ram_we    = !is_nl;
                ram_waddr = mac_p;
                ram_wdata = {tcw_pkg::ATTR_NORMAL, r_ch};
            end
            tcw_pkg::S_READ: begin
                ram_re = 1'b1;
            end
            tcw_pkg::S_AREA: begin
                // start of the last active row: (h - 1) * w
                mac_a = ROW_W'(r_h - 1'b1);
                mac_b = r_w;
                mac_c = '0;
            end
            tcw_pkg::S_PREFETCH: begin
                ram_re    = r_move;
                ram_raddr = ADDR_W'(r_w);
            end
            tcw_pkg::S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = (r_move && (r_idx < r_lim)) ? ram_rdata : '0;
                ram_re    = r_move && (sweep_rd < (ADDR_W+1)'(CELLS));
                ram_raddr = ADDR_W'(sweep_rd);
            end
            tcw_pkg::S_RESULT: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_SWEEP;
            r_idx   <= '0;
            r_last  <= ADDR_W'(CELLS - 1);
            r_lim   <= '0;
            r_move  <= 1'b0;
            r_init  <= 1'b1;
            r_col   <= '0;
            r_line  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                tcw_pkg::S_IDLE: begin
                    r_move <= 1'b0;
                end
                tcw_pkg::S_PUT: begin
                    r_col  <= put_col;
                    r_line <= put_line;
                    r_move <= put_scroll;
                end
                tcw_pkg::S_LIMIT: begin
                    // on a scroll, cells before the last active row are copied up a row, the rest zeroed
                    r_idx  <= '0;
                    r_lim  <= mac_p;
                    r_last <= ADDR_W'(mac_p + ADDR_W'(r_w) - ADDR_W'(1));
                end
                tcw_pkg::S_SWEEP: begin
                    if (sweep_end) begin
                        r_init <= 1'b0;
                    end else begin
                        r_idx <= ADDR_W'(r_idx + 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // configuration registers, saturated on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= COL_W'(W_RST);
            r_h <= ROW_W'(H_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcw_pkg::REG_ACTIVE_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_w <= COL_W'(1);
                    end else if (int'(i_cfg_data) > MAX_COLS) begin
                        r_w <= COL_W'(MAX_COLS);
                    end else begin
                        r_w <= COL_W'(i_cfg_data);
                    end
                end
                tcw_pkg::REG_ACTIVE_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_h <= ROW_W'(1);
                    end else if (int'(i_cfg_data) > MAX_ROWS) begin
                        r_h <= ROW_W'(MAX_ROWS);
                    end else begin
                        r_h <= ROW_W'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // command beat and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= tcw_pkg::t_cmd'(i_cmd);
            r_ch         <= i_char_code;
            r_px         <= px_clamped;
            r_py         <= py_clamped;
            r_echo_valid <= (tcw_pkg::t_cmd'(i_cmd) == tcw_pkg::CMD_PUT) ||
                            (tcw_pkg::t_cmd'(i_cmd) == tcw_pkg::CMD_PUT_AT);
            r_echo_byte  <= ((tcw_pkg::t_cmd'(i_cmd) == tcw_pkg::CMD_PUT) ||
                             (tcw_pkg::t_cmd'(i_cmd) == tcw_pkg::CMD_PUT_AT))
                            ? i_char_code : '0;
            r_scrolled   <= 1'b0;
            r_rd_char    <= '0;
            r_rd_attr    <= '0;
        end
        if (r_state == tcw_pkg::S_PUT) begin
            r_scrolled <= put_scroll;
        end
        // read data lands in the cycle after the read is issued
        if (r_state == tcw_pkg::S_RDWAIT) begin
            r_rd_char <= ram_rdata[tcw_pkg::CHAR_W-1:0];
            r_rd_attr <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
    end

    assign o_echo_valid = r_echo_valid;
    assign o_echo_byte  = r_echo_byte;
    assign o_cursor_col = tcw_pkg::POS_X_W'(r_col);
    assign o_cursor_row = tcw_pkg::POS_Y_W'(r_line);
    assign o_scrolled   = r_scrolled;
    assign o_read_char  = r_rd_char;
    assign o_read_attr  = r_rd_attr;

    // checks

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // a scroll only follows put at cursor and leaves the cursor on the last row
    a_scroll_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (r_cmd == tcw_pkg::CMD_PUT))
        else $error("scroll reported for a command other than put");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (r_line == ROW_W'(r_h - 1'b1)))
        else $error("cursor not on last active row after scroll");

    // the result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule
